/* rtl/core/srclex_pkg.sv */
package srclex_pkg;

  // Defaults for the top level's parameter
  localparam int POSITION_BITS = 16;

  // Longest word kept; one more word byte gives an error token
  localparam logic [7:0] MAX_WORD_LENGTH = 8'd255;

  localparam int KW_COUNT   = 13;
  localparam int OUTQ_DEPTH = 4;
  localparam int MIDQ_DEPTH = 2;

  typedef logic [5:0] ttype_t;

  // Token type codes
  localparam ttype_t TT_NULL         = 6'd0;
  localparam ttype_t TT_IDENT        = 6'd1;
  localparam ttype_t TT_NUMBER       = 6'd2;
  localparam ttype_t TT_SEMI         = 6'd3;
  localparam ttype_t TT_STRUCTURE    = 6'd4;
  localparam ttype_t TT_INTERFACE    = 6'd5;
  localparam ttype_t TT_TEMPLATE     = 6'd6;
  localparam ttype_t TT_TYPEDEF      = 6'd7;
  localparam ttype_t TT_RETURN       = 6'd8;
  localparam ttype_t TT_NEWLINE      = 6'd9;
  localparam ttype_t TT_UNSIGNED     = 6'd20;
  localparam ttype_t TT_SIGNED       = 6'd21;
  localparam ttype_t TT_IMPLEMENTS   = 6'd22;
  localparam ttype_t TT_EXTENDS      = 6'd23;
  localparam ttype_t TT_INT          = 6'd24;
  localparam ttype_t TT_FLOAT        = 6'd25;
  localparam ttype_t TT_CHAR         = 6'd26;
  localparam ttype_t TT_VOID         = 6'd27;
  localparam ttype_t TT_LBRACE       = 6'd28;
  localparam ttype_t TT_RBRACE       = 6'd29;
  localparam ttype_t TT_LPAREN       = 6'd30;
  localparam ttype_t TT_RPAREN       = 6'd31;
  localparam ttype_t TT_LBRACK       = 6'd32;
  localparam ttype_t TT_RBRACK       = 6'd33;
  localparam ttype_t TT_AMP          = 6'd34;
  localparam ttype_t TT_ASSIGN       = 6'd35;
  localparam ttype_t TT_PLUS         = 6'd36;
  localparam ttype_t TT_MINUS        = 6'd37;
  localparam ttype_t TT_STAR         = 6'd38;
  localparam ttype_t TT_SLASH        = 6'd39;
  localparam ttype_t TT_EQ           = 6'd40;
  localparam ttype_t TT_NE           = 6'd41;
  localparam ttype_t TT_GT           = 6'd42;
  localparam ttype_t TT_LT           = 6'd43;
  localparam ttype_t TT_GE           = 6'd44;
  localparam ttype_t TT_LE           = 6'd45;
  localparam ttype_t TT_BANG         = 6'd48;
  localparam ttype_t TT_PERCENT      = 6'd49;
  localparam ttype_t TT_INC          = 6'd50;
  localparam ttype_t TT_DEC          = 6'd51;
  localparam ttype_t TT_PLUS_EQ      = 6'd52;
  localparam ttype_t TT_MINUS_EQ     = 6'd53;
  localparam ttype_t TT_STAR_EQ      = 6'd54;
  localparam ttype_t TT_SLASH_EQ     = 6'd55;
  localparam ttype_t TT_PERCENT_EQ   = 6'd56;
  localparam ttype_t TT_LINE_COMMENT = 6'd57;
  localparam ttype_t TT_BLOCK_OPEN   = 6'd58;
  localparam ttype_t TT_BLOCK_CLOSE  = 6'd59;

  // Characters
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = " ";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_PERCENT = "%";
  localparam logic [7:0] CH_LT      = "<";
  localparam logic [7:0] CH_GT      = ">";
  localparam logic [7:0] CH_BANG    = "!";
  localparam logic [7:0] CH_EQUAL   = "=";
  localparam logic [7:0] CH_SEMI    = ";";
  localparam logic [7:0] CH_LBRACE  = "{";
  localparam logic [7:0] CH_RBRACE  = "}";
  localparam logic [7:0] CH_LPAREN  = "(";
  localparam logic [7:0] CH_RPAREN  = ")";
  localparam logic [7:0] CH_LBRACK  = "[";
  localparam logic [7:0] CH_RBRACK  = "]";
  localparam logic [7:0] CH_AMP     = "&";
  localparam logic [7:0] CH_USCORE  = "_";
  localparam logic [7:0] CH_0       = "0";
  localparam logic [7:0] CH_9       = "9";
  localparam logic [7:0] CH_LA      = "a";
  localparam logic [7:0] CH_LZ      = "z";
  localparam logic [7:0] CH_UA      = "A";
  localparam logic [7:0] CH_UZ      = "Z";

  // Byte kinds, set by the front end
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_WORD    = 3'd0;
  localparam kind_t KIND_SPACE   = 3'd1;
  localparam kind_t KIND_NEWLINE = 3'd2;
  localparam kind_t KIND_LEAD    = 3'd3;
  localparam kind_t KIND_SOLO    = 3'd4;

  // Word classes
  localparam logic [1:0] WC_EMPTY   = 2'd0;
  localparam logic [1:0] WC_IDENT   = 2'd1;
  localparam logic [1:0] WC_NUMBER  = 2'd2;
  localparam logic [1:0] WC_INVALID = 2'd3;

  // Keywords, text right-justified, first char at the top
  localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
    "structure", "interface", "template", "typedef", "return", "unsigned",
    "signed", "implements", "extends", "int", "float", "char", "void"
  };
  localparam int KW_LEN [KW_COUNT] = '{9, 9, 8, 7, 6, 8, 6, 10, 7, 3, 5, 4, 4};
  localparam ttype_t KW_CODE [KW_COUNT] = '{
    TT_STRUCTURE, TT_INTERFACE, TT_TEMPLATE, TT_TYPEDEF, TT_RETURN, TT_UNSIGNED,
    TT_SIGNED, TT_IMPLEMENTS, TT_EXTENDS, TT_INT, TT_FLOAT, TT_CHAR, TT_VOID
  };

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } text_word_t;

  typedef struct packed {
    ttype_t      tok_code;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        word_too_long;
    logic        last_in_run;
  } token_word_t;

  // Classified byte, front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    kind_t      kind;
    ttype_t     solo;
    logic       is_digit;
    logic       is_alpha;
  } lex_item_t;

  // Up to two tokens from one byte, back to output queue
  typedef struct packed {
    logic [1:0]  count;
    token_word_t first;
    token_word_t second;
  } result_pair_t;

  // Single-char code of a byte that may begin a pair, else null
  function automatic ttype_t pair_lead(input logic [7:0] c);
    ttype_t t;
    unique case (c)
      CH_PLUS:    t = TT_PLUS;
      CH_MINUS:   t = TT_MINUS;
      CH_STAR:    t = TT_STAR;
      CH_SLASH:   t = TT_SLASH;
      CH_PERCENT: t = TT_PERCENT;
      CH_LT:      t = TT_LT;
      CH_GT:      t = TT_GT;
      CH_BANG:    t = TT_BANG;
      CH_EQUAL:   t = TT_ASSIGN;
      default:    t = TT_NULL;
    endcase
    return t;
  endfunction

  function automatic ttype_t pair_code(input logic [7:0] a, input logic [7:0] b);
    ttype_t t;
    t = TT_NULL;
    unique case (a)
      CH_PLUS: begin
        if (b == CH_EQUAL) t = TT_PLUS_EQ;
        else if (b == CH_PLUS) t = TT_INC;
      end
      CH_MINUS: begin
        if (b == CH_EQUAL) t = TT_MINUS_EQ;
        else if (b == CH_MINUS) t = TT_DEC;
      end
      CH_STAR: begin
        if (b == CH_EQUAL) t = TT_STAR_EQ;
        else if (b == CH_SLASH) t = TT_BLOCK_CLOSE;
      end
      CH_SLASH: begin
        if (b == CH_EQUAL) t = TT_SLASH_EQ;
        else if (b == CH_SLASH) t = TT_LINE_COMMENT;
        else if (b == CH_STAR) t = TT_BLOCK_OPEN;
      end
      CH_PERCENT: if (b == CH_EQUAL) t = TT_PERCENT_EQ;
      CH_LT:      if (b == CH_EQUAL) t = TT_LE;
      CH_GT:      if (b == CH_EQUAL) t = TT_GE;
      CH_BANG:    if (b == CH_EQUAL) t = TT_NE;
      CH_EQUAL:   if (b == CH_EQUAL) t = TT_EQ;
      default:    t = TT_NULL;
    endcase
    return t;
  endfunction

  function automatic ttype_t solo_code(input logic [7:0] c);
    ttype_t t;
    unique case (c)
      CH_SEMI:   t = TT_SEMI;
      CH_LBRACE: t = TT_LBRACE;
      CH_RBRACE: t = TT_RBRACE;
      CH_LPAREN: t = TT_LPAREN;
      CH_RPAREN: t = TT_RPAREN;
      CH_LBRACK: t = TT_LBRACK;
      CH_RBRACK: t = TT_RBRACK;
      CH_AMP:    t = TT_AMP;
      default:   t = TT_NULL;
    endcase
    return t;
  endfunction

  // Keyword idx still matches after byte c at offset wlen
  function automatic logic kw_hit(input int idx, input logic [7:0] wlen,
                                  input logic [7:0] c);
    int   sel;
    logic hit;
    hit = 1'b0;
    sel = 0;
    if (wlen < 8'(KW_LEN[idx])) begin
      sel = KW_LEN[idx] - 1 - int'(wlen);
      hit = (KW_TEXT[idx][sel*8 +: 8] == c);
    end
    return hit;
  endfunction

endpackage

/* rtl/core/srclex_queue.sv */
module srclex_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    rd;
  logic [PW-1:0]    wr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign rdata = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= '0;
      wr    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= (wr == PW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      if (pop) rd <= (rd == PW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= wdata;
  end

endmodule

/* rtl/core/srclex_front.sv */
module srclex_front (
  input  logic                   text_valid,
  output logic                   text_stall,
  input  srclex_pkg::text_word_t text_word,
  input  logic                   queue_full,
  output logic                   push,
  output srclex_pkg::lex_item_t  item
);

  logic [7:0]         c;
  srclex_pkg::ttype_t lead;
  srclex_pkg::ttype_t solo;

  assign c          = text_word.char_in;
  assign text_stall = queue_full;
  assign push       = text_valid && !queue_full;
  assign lead       = srclex_pkg::pair_lead(c);
  assign solo       = srclex_pkg::solo_code(c);

  always_comb begin
    item.ch       = c;
    item.last     = text_word.end_of_text;
    item.solo     = solo;
    item.is_digit = (c >= srclex_pkg::CH_0) && (c <= srclex_pkg::CH_9);
    item.is_alpha = (c == srclex_pkg::CH_USCORE) ||
                    ((c >= srclex_pkg::CH_LA) && (c <= srclex_pkg::CH_LZ)) ||
                    ((c >= srclex_pkg::CH_UA) && (c <= srclex_pkg::CH_UZ));
    priority if (c == srclex_pkg::CH_SPACE || c == srclex_pkg::CH_TAB) begin
      item.kind = srclex_pkg::KIND_SPACE;
    end else if (c == srclex_pkg::CH_LF) begin
      item.kind = srclex_pkg::KIND_NEWLINE;
    end else if (lead != srclex_pkg::TT_NULL) begin
      item.kind = srclex_pkg::KIND_LEAD;
    end else if (solo != srclex_pkg::TT_NULL) begin
      item.kind = srclex_pkg::KIND_SOLO;
    end else begin
      item.kind = srclex_pkg::KIND_WORD;
    end
  end

endmodule

/* rtl/core/srclex_back.sv */
module srclex_back #(
  parameter int POSITION_BITS = srclex_pkg::POSITION_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  srclex_pkg::lex_item_t   item,
  input  logic                    room,
  output logic                    item_pop,
  output srclex_pkg::result_pair_t pair
);

  logic [7:0]               pend_op,    pend_op_next;
  logic                     pend_v,     pend_v_next;
  logic [7:0]               wlen,       wlen_next;
  logic [15:0]              wstart,     wstart_next;
  logic [1:0]               wclass,     wclass_next;
  logic [srclex_pkg::KW_COUNT-1:0] kw, kw_next;
  logic [POSITION_BITS-1:0] pos,        pos_next;

  logic [POSITION_BITS-1:0] pos_prev;
  logic [15:0]              pos16;
  logic [15:0]              prev16;
  logic                     fire;
  logic                     consumed;
  srclex_pkg::ttype_t       two;
  logic [1:0]               n;
  srclex_pkg::token_word_t  res [2];

  function automatic srclex_pkg::token_word_t make_token(
      input srclex_pkg::ttype_t t, input logic [15:0] start,
      input logic [7:0] len, input logic err);
    srclex_pkg::token_word_t w;
    w.tok_code      = t;
    w.token_start   = start;
    w.token_length  = len;
    w.word_too_long = err;
    w.last_in_run   = 1'b0;
    return w;
  endfunction

  // Keyword wins over identifier when its full text matched
  function automatic srclex_pkg::ttype_t word_type(
      input logic [1:0] cls, input logic [srclex_pkg::KW_COUNT-1:0] m,
      input logic [7:0] len);
    srclex_pkg::ttype_t t;
    t = (cls == srclex_pkg::WC_IDENT)  ? srclex_pkg::TT_IDENT :
        (cls == srclex_pkg::WC_NUMBER) ? srclex_pkg::TT_NUMBER : srclex_pkg::TT_NULL;
    for (int i = 0; i < srclex_pkg::KW_COUNT; i++) begin
      if (m[i] && len == 8'(srclex_pkg::KW_LEN[i])) t = srclex_pkg::KW_CODE[i];
    end
    return t;
  endfunction

  assign fire     = item_valid && room;
  assign item_pop = fire;
  assign pos_prev = pos - 1'b1;
  assign pos16    = 16'(pos);
  assign prev16   = 16'(pos_prev);

  always_comb begin
    pend_op_next = pend_op;
    pend_v_next  = pend_v;
    wlen_next    = wlen;
    wstart_next  = wstart;
    wclass_next  = wclass;
    kw_next      = kw;
    pos_next     = pos + 1'b1;
    consumed     = 1'b0;
    two          = srclex_pkg::TT_NULL;
    n            = 2'd0;
    res[0]       = '0;
    res[1]       = '0;

    // held operator: pair with this byte or go out alone
    if (pend_v) begin
      two = srclex_pkg::pair_code(pend_op, item.ch);
      if (two != srclex_pkg::TT_NULL) begin
        res[n[0]] = make_token(two, prev16, 8'd2, 1'b0);
        consumed  = 1'b1;
      end else begin
        res[n[0]] = make_token(srclex_pkg::pair_lead(pend_op), prev16, 8'd1, 1'b0);
      end
      n           = n + 2'd1;
      pend_v_next = 1'b0;
    end

    if (!consumed) begin
      if (item.kind != srclex_pkg::KIND_WORD) begin
        if (wlen_next != 8'd0) begin
          res[n[0]] = make_token(word_type(wclass_next, kw_next, wlen_next),
                                 wstart_next, wlen_next, 1'b0);
          n           = n + 2'd1;
          wlen_next   = 8'd0;
          wclass_next = srclex_pkg::WC_EMPTY;
          kw_next     = '1;
        end
        unique case (item.kind)
          srclex_pkg::KIND_NEWLINE: begin
            res[n[0]] = make_token(srclex_pkg::TT_NEWLINE, pos16, 8'd1, 1'b0);
            n         = n + 2'd1;
          end
          srclex_pkg::KIND_LEAD: begin
            pend_op_next = item.ch;
            pend_v_next  = 1'b1;
          end
          srclex_pkg::KIND_SOLO: begin
            res[n[0]] = make_token(item.solo, pos16, 8'd1, 1'b0);
            n         = n + 2'd1;
          end
          default: ;
        endcase
      end else if (wlen_next >= srclex_pkg::MAX_WORD_LENGTH) begin
        // overlong word: error token, byte and word dropped
        res[n[0]]   = make_token(srclex_pkg::TT_NULL, wstart_next, wlen_next, 1'b1);
        n           = n + 2'd1;
        wlen_next   = 8'd0;
        wclass_next = srclex_pkg::WC_EMPTY;
        kw_next     = '1;
      end else begin
        if (wlen_next == 8'd0) begin
          wstart_next = pos16;
          wclass_next = item.is_digit ? srclex_pkg::WC_NUMBER :
                        item.is_alpha ? srclex_pkg::WC_IDENT : srclex_pkg::WC_INVALID;
        end else if (wclass_next == srclex_pkg::WC_IDENT) begin
          if (!(item.is_alpha || item.is_digit)) wclass_next = srclex_pkg::WC_INVALID;
        end else if (wclass_next == srclex_pkg::WC_NUMBER) begin
          if (!item.is_digit) wclass_next = srclex_pkg::WC_INVALID;
        end
        for (int i = 0; i < srclex_pkg::KW_COUNT; i++) begin
          if (!srclex_pkg::kw_hit(i, wlen_next, item.ch)) kw_next[i] = 1'b0;
        end
        wlen_next = wlen_next + 8'd1;
      end
    end

    // end of text: flush operator, then word, then start over
    if (item.last) begin
      if (pend_v_next) begin
        res[n[0]] = make_token(srclex_pkg::pair_lead(pend_op_next), pos16, 8'd1, 1'b0);
        n         = n + 2'd1;
      end
      if (wlen_next != 8'd0) begin
        res[n[0]] = make_token(word_type(wclass_next, kw_next, wlen_next),
                               wstart_next, wlen_next, 1'b0);
        n         = n + 2'd1;
      end
      pend_op_next = 8'd0;
      pend_v_next  = 1'b0;
      wlen_next    = 8'd0;
      wstart_next  = 16'd0;
      wclass_next  = srclex_pkg::WC_EMPTY;
      kw_next      = '1;
      pos_next     = '0;
    end

    if (n == 2'd2) res[1].last_in_run = 1'b1;
    else if (n == 2'd1) res[0].last_in_run = 1'b1;

    pair.count  = fire ? n : 2'd0;
    pair.first  = res[0];
    pair.second = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_op <= 8'd0;
      pend_v  <= 1'b0;
      wlen    <= 8'd0;
      wstart  <= 16'd0;
      wclass  <= srclex_pkg::WC_EMPTY;
      kw      <= '1;
      pos     <= '0;
    end else if (fire) begin
      pend_op <= pend_op_next;
      pend_v  <= pend_v_next;
      wlen    <= wlen_next;
      wstart  <= wstart_next;
      wclass  <= wclass_next;
      kw      <= kw_next;
      pos     <= pos_next;
    end
  end

endmodule

/* rtl/core/srclex_outq.sv */
module srclex_outq (
  input  logic                     clk,
  input  logic                     rst,
  input  srclex_pkg::result_pair_t pair,
  output logic                     room,
  output logic                     token_valid,
  input  logic                     token_stall,
  output srclex_pkg::token_word_t  token_word
);

  localparam int PW = $clog2(srclex_pkg::OUTQ_DEPTH);
  localparam int CW = $clog2(srclex_pkg::OUTQ_DEPTH + 1);

  srclex_pkg::token_word_t mem [srclex_pkg::OUTQ_DEPTH];
  logic [PW-1:0] rd;
  logic [PW-1:0] wr;
  logic [CW-1:0] count;
  logic          pop;

  assign token_valid = (count != '0);
  assign token_word  = mem[rd];
  assign pop         = token_valid && !token_stall;
  // two free slots needed before the back end may fire
  assign room        = (count <= CW'(srclex_pkg::OUTQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= '0;
      wr    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + PW'(pair.count);
      rd    <= rd + PW'(pop);
      count <= count + CW'(pair.count) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pair.count != 2'd0) mem[wr] <= pair.first;
    if (pair.count == 2'd2) mem[wr + 1'b1] <= pair.second;
  end

endmodule

/* rtl/core/source_text_lexer.sv */
// Streaming source text lexer.
// text channel: one word per byte (char_in, end_of_text), valid/stall.
// token channel: one word per token (type, start offset, length,
//   word_too_long, last_in_run), valid/stall.
// A byte gives zero, one or two tokens; last_in_run marks the last one of
// each byte that gives any. Bytes that only extend a word or hold an
// operator give none.
// A byte is classified into the 2-entry queue as it is accepted; the lexer
// step takes it from there and writes its tokens into the 4-entry token
// queue. The block takes one byte per cycle while bytes give at most one
// token and the token side does not stall; bytes giving two tokens fill
// the token queue faster than the single token output port drains it.
// end_of_text flushes the held operator and word, then offsets restart at 0.
// Reset clears both queues and all lexer state; no tokens are pending.
// A stalled token holds still; the queues then fill and text_stall rises,
// never dropping a byte.
module source_text_lexer #(
  parameter int POSITION_BITS = srclex_pkg::POSITION_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    text_valid,
  output logic                    text_stall,
  input  srclex_pkg::text_word_t  text_word,
  output logic                    token_valid,
  input  logic                    token_stall,
  output srclex_pkg::token_word_t token_word
);

  localparam int ITEM_W = $bits(srclex_pkg::lex_item_t);

  logic                     q_full;
  logic                     q_empty;
  logic                     q_push;
  logic                     q_pop;
  srclex_pkg::lex_item_t    front_item;
  srclex_pkg::lex_item_t    back_item;
  logic                     room;
  srclex_pkg::result_pair_t pair;

  // Front end: classify each byte as it is accepted
  srclex_front u_front (
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_word  (text_word),
    .queue_full (q_full),
    .push       (q_push),
    .item       (front_item)
  );

  // Decoupling queue between classifier and lexer state
  srclex_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (srclex_pkg::MIDQ_DEPTH)
  ) u_midq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (front_item),
    .pop   (q_pop),
    .rdata (back_item),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back end: word gathering, keyword match, operator pairing
  srclex_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!q_empty),
    .item       (back_item),
    .room       (room),
    .item_pop   (q_pop),
    .pair       (pair)
  );

  // Token queue: takes up to two per cycle, hands out one when not stalled
  srclex_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .pair        (pair),
    .room        (room),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_word  (token_word)
  );

endmodule

/* rtl/core/srclex_checker.sv */
module srclex_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    text_stall,
  input logic                    token_valid,
  input logic                    token_stall,
  input srclex_pkg::token_word_t token_word
);

  // Reset empties both queues
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!token_valid && !text_stall))
    else $error("queues not empty after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_stall) |=> token_valid)
    else $error("token dropped while stalled");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_stall) |=> $stable(token_word))
    else $error("token changed while stalled");

  // Error tokens carry null type and the length limit
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_word.word_too_long) |->
      (token_word.tok_code == srclex_pkg::TT_NULL &&
       token_word.token_length == srclex_pkg::MAX_WORD_LENGTH))
    else $error("bad overlong word token");

endmodule

bind source_text_lexer srclex_checker u_checker (.*);

/* verif/source_text_lexer_tb.sv */
`timescale 1ns / 1ps

module source_text_lexer_tb;
  import srclex_pkg::*;

  localparam int HOLD_CYCLES = 300;  // long token hold-off for the fill-up test
  localparam int GAP_PCT     = 34;   // idle chance per cycle on either side

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  text_word_t  text_word = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  token_word_t token_word;

  source_text_lexer DUT (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_word  (text_word),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_word (token_word)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lexer mirror: same state as the block, updated once per accepted text word.
  // Tokens it works out wait in token_q until the block hands them over.
  // ---------------------------------------------------------------------------
  string  kw_spell [13] = '{
    "structure", "interface", "template", "typedef", "return", "unsigned",
    "signed", "implements", "extends", "int", "float", "char", "void"
  };
  ttype_t kw_type [13] = '{
    TT_STRUCTURE, TT_INTERFACE, TT_TEMPLATE, TT_TYPEDEF, TT_RETURN, TT_UNSIGNED,
    TT_SIGNED, TT_IMPLEMENTS, TT_EXTENDS, TT_INT, TT_FLOAT, TT_CHAR, TT_VOID
  };
  logic [7:0] lead_chars [9] = '{
    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT, CH_LT, CH_GT, CH_BANG, CH_EQUAL
  };
  logic [7:0] solo_chars [8] = '{
    CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_AMP
  };

  logic [7:0]  m_pend_op;
  logic        m_pend_vld;
  int          m_wlen;
  logic [15:0] m_wstart;
  logic [1:0]  m_wclass;
  logic [12:0] m_kw_alive;
  logic [15:0] m_pos;

  token_word_t run_buf [2];   // tokens caused by the current byte, text order
  int          run_n;
  token_word_t token_q [$];   // tokens still owed by the block

  // Test-side bookkeeping
  int          bytes_sent  = 0;
  int          err_count   = 0;
  bit          quiet       = 1'b0;  // no idling on either side
  int          hold_ticket = 0;     // bumped to request one long token hold-off
  int          hold_served = 0;
  int          hold_left   = 0;
  token_word_t want;

  function automatic ttype_t lead_type(input logic [7:0] c);
    case (c)
      CH_PLUS:    return TT_PLUS;
      CH_MINUS:   return TT_MINUS;
      CH_STAR:    return TT_STAR;
      CH_SLASH:   return TT_SLASH;
      CH_PERCENT: return TT_PERCENT;
      CH_LT:      return TT_LT;
      CH_GT:      return TT_GT;
      CH_BANG:    return TT_BANG;
      CH_EQUAL:   return TT_ASSIGN;
      default:    return TT_NULL;
    endcase
  endfunction

  function automatic ttype_t pair_type(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      {CH_PLUS, CH_EQUAL}:    return TT_PLUS_EQ;
      {CH_PLUS, CH_PLUS}:     return TT_INC;
      {CH_MINUS, CH_EQUAL}:   return TT_MINUS_EQ;
      {CH_MINUS, CH_MINUS}:   return TT_DEC;
      {CH_STAR, CH_EQUAL}:    return TT_STAR_EQ;
      {CH_STAR, CH_SLASH}:    return TT_BLOCK_CLOSE;
      {CH_SLASH, CH_EQUAL}:   return TT_SLASH_EQ;
      {CH_SLASH, CH_SLASH}:   return TT_LINE_COMMENT;
      {CH_SLASH, CH_STAR}:    return TT_BLOCK_OPEN;
      {CH_PERCENT, CH_EQUAL}: return TT_PERCENT_EQ;
      {CH_LT, CH_EQUAL}:      return TT_LE;
      {CH_GT, CH_EQUAL}:      return TT_GE;
      {CH_BANG, CH_EQUAL}:    return TT_NE;
      {CH_EQUAL, CH_EQUAL}:   return TT_EQ;
      default:                return TT_NULL;
    endcase
  endfunction

  function automatic ttype_t solo_type(input logic [7:0] c);
    case (c)
      CH_SEMI:   return TT_SEMI;
      CH_LBRACE: return TT_LBRACE;
      CH_RBRACE: return TT_RBRACE;
      CH_LPAREN: return TT_LPAREN;
      CH_RPAREN: return TT_RPAREN;
      CH_LBRACK: return TT_LBRACK;
      CH_RBRACK: return TT_RBRACK;
      CH_AMP:    return TT_AMP;
      default:   return TT_NULL;
    endcase
  endfunction

  function automatic void emit(input ttype_t t, input logic [15:0] s,
                               input logic [7:0] l, input logic e);
    token_word_t tok;
    tok.tok_code      = t;
    tok.token_start   = s;
    tok.token_length  = l;
    tok.word_too_long = e;
    tok.last_in_run   = 1'b0;
    run_buf[run_n]    = tok;
    run_n++;
  endfunction

  function automatic void clear_word();
    m_wlen     = 0;
    m_wclass   = WC_EMPTY;
    m_kw_alive = '1;
  endfunction

  function automatic void reset_lexer();
    m_pend_op  = '0;
    m_pend_vld = 1'b0;
    m_wstart   = '0;
    m_pos      = '0;
    clear_word();
  endfunction

  // Closes the open word; a full keyword match overrides the class
  function automatic void flush_word();
    ttype_t t;
    int     i;
    if (m_wlen == 0) return;
    t = (m_wclass == WC_IDENT) ? TT_IDENT : (m_wclass == WC_NUMBER) ? TT_NUMBER : TT_NULL;
    for (i = 0; i < 13; i++)
      if (m_kw_alive[i] && kw_spell[i].len() == m_wlen) t = kw_type[i];
    emit(t, m_wstart, m_wlen[7:0], 1'b0);
    clear_word();
  endfunction

  function automatic void add_word_byte(input logic [7:0] c, input logic [15:0] pos);
    logic digit;
    logic alpha;
    int   i;
    digit = (c >= CH_0 && c <= CH_9);
    alpha = (c == CH_USCORE) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    if (m_wlen == 0) begin
      m_wstart = pos;
      m_wclass = digit ? WC_NUMBER : alpha ? WC_IDENT : WC_INVALID;
    end else if (m_wclass == WC_IDENT && !(alpha || digit)) begin
      m_wclass = WC_INVALID;
    end else if (m_wclass == WC_NUMBER && !digit) begin
      m_wclass = WC_INVALID;
    end
    for (i = 0; i < 13; i++)
      if (!(m_wlen < kw_spell[i].len() && kw_spell[i][m_wlen] == c)) m_kw_alive[i] = 1'b0;
    m_wlen++;
  endfunction

  // One accepted text word: works out the 0..2 tokens it causes
  function automatic void lex_byte(input text_word_t w);
    logic [7:0]  c;
    logic [15:0] pos;
    logic        taken;
    ttype_t      two;
    int          i;
    token_word_t tok;
    c     = w.char_in;
    pos   = m_pos;
    taken = 1'b0;
    run_n = 0;
    // held operator either pairs with this byte or goes out alone
    if (m_pend_vld) begin
      two = pair_type(m_pend_op, c);
      if (two != TT_NULL) begin
        emit(two, pos - 16'd1, 8'd2, 1'b0);
        taken = 1'b1;
      end else begin
        emit(lead_type(m_pend_op), pos - 16'd1, 8'd1, 1'b0);
      end
      m_pend_vld = 1'b0;
    end
    if (!taken) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
        flush_word();
        if (c == CH_LF) emit(TT_NEWLINE, pos, 8'd1, 1'b0);
      end else if (lead_type(c) != TT_NULL) begin
        flush_word();
        m_pend_op  = c;
        m_pend_vld = 1'b1;
      end else if (solo_type(c) != TT_NULL) begin
        flush_word();
        emit(solo_type(c), pos, 8'd1, 1'b0);
      end else if (m_wlen >= MAX_WORD_LENGTH) begin
        // overlong word: error token, byte and word dropped
        emit(TT_NULL, m_wstart, m_wlen[7:0], 1'b1);
        clear_word();
      end else begin
        add_word_byte(c, pos);
      end
    end
    m_pos = pos + 16'd1;
    if (w.end_of_text) begin
      if (m_pend_vld) emit(lead_type(m_pend_op), pos, 8'd1, 1'b0);
      flush_word();
      reset_lexer();
    end
    for (i = 0; i < run_n; i++) begin
      tok = run_buf[i];
      tok.last_in_run = (i == run_n - 1);
      token_q.push_back(tok);
    end
  endfunction

  initial reset_lexer();

  // ---------------------------------------------------------------------------
  // Token side: stall pattern and checking
  // ---------------------------------------------------------------------------
  // Priority: long hold-off, then quiet stretch, then random stalls.
  always @(negedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
    end else if (hold_left > 0) begin
      token_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      token_stall <= 1'b1;
    end else if (quiet) begin
      token_stall <= 1'b0;
    end else begin
      token_stall <= ($urandom_range(99) < GAP_PCT);
    end
  end

  // Every accepted token word is matched against the oldest owed token
  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) begin
      if (token_q.size() == 0) begin
        if (err_count < 10)
          $display("%0t: unowed token: type %0d start %0d len %0d long %0b last %0b",
                   $time, token_word.tok_code, token_word.token_start,
                   token_word.token_length, token_word.word_too_long,
                   token_word.last_in_run);
        err_count++;
      end else begin
        want = token_q.pop_front();
        if (token_word !== want) begin
          if (err_count < 10)
            $display({"%0t: token mismatch: want type %0d start %0d len %0d long %0b",
                      " last %0b / got type %0d start %0d len %0d long %0b last %0b"},
                     $time, want.tok_code, want.token_start, want.token_length,
                     want.word_too_long, want.last_in_run, token_word.tok_code,
                     token_word.token_start, token_word.token_length,
                     token_word.word_too_long, token_word.last_in_run);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Text side
  // ---------------------------------------------------------------------------
  // Offers one text word from a falling edge after any idle gaps, returns at the
  // rising edge that accepts it. valid stays high until the next call decides.
  task automatic send_byte(input logic [7:0] c, input logic eot);
    text_word_t w;
    w.char_in     = c;
    w.end_of_text = eot;
    @(negedge clk);
    if (!quiet)
      while ($urandom_range(99) < GAP_PCT) begin
        text_valid <= 1'b0;
        @(negedge clk);
      end
    text_valid <= 1'b1;
    text_word  <= w;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    lex_byte(w);
    bytes_sent++;
  endtask

  // end_of_text goes on the last byte when eot_last is set
  task automatic send_text(input string s, input bit eot_last);
    int i;
    for (i = 0; i < s.len(); i++)
      send_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_alpha();
    int r;
    r = $urandom_range(52);
    if (r == 52) return CH_USCORE;
    if (r < 26) return CH_LA + 8'(r);
    return CH_UA + 8'(r - 26);
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_0 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_sep();
    int r;
    r = $urandom_range(9);
    return (r < 6) ? CH_SPACE : (r < 8) ? CH_TAB : CH_LF;
  endfunction

  function automatic logic [7:0] pick_any();
    case ($urandom_range(6))
      0:       return pick_alpha();
      1:       return pick_digit();
      2:       return pick_sep();
      3:       return lead_chars[$urandom_range(8)];
      4:       return solo_chars[$urandom_range(7)];
      5:       return CH_EQUAL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One piece of plausible source text, mostly followed by a separator
  task automatic send_fragment();
    int         kind;
    int         n;
    int         i;
    int         k;
    logic [7:0] c;
    kind = $urandom_range(199);
    if (kind < 36) begin
      // keyword, sometimes cut short or run on
      k = $urandom_range(12);
      n = $urandom_range(2);
      for (i = 0; i < kw_spell[k].len() - (n == 1); i++) send_byte(kw_spell[k][i], 1'b0);
      if (n == 2) send_byte(($urandom_range(1) ? pick_alpha() : pick_digit()), 1'b0);
    end else if (kind < 72) begin
      send_byte(pick_alpha(), 1'b0);
      n = $urandom_range(10);
      for (i = 0; i < n; i++)
        send_byte(($urandom_range(3) == 0) ? pick_digit() : pick_alpha(), 1'b0);
    end else if (kind < 96) begin
      n = $urandom_range(8, 1);
      for (i = 0; i < n; i++) send_byte(pick_digit(), 1'b0);
    end else if (kind < 136) begin
      c = lead_chars[$urandom_range(8)];
      send_byte(c, 1'b0);
      case ($urandom_range(4))
        1: send_byte(CH_EQUAL, 1'b0);
        2: send_byte(c, 1'b0);
        3: send_byte(($urandom_range(1) ? CH_SLASH : CH_STAR), 1'b0);
        4: send_byte(lead_chars[$urandom_range(8)], 1'b0);
        default: ;
      endcase
    end else if (kind < 156) begin
      send_byte(solo_chars[$urandom_range(7)], 1'b0);
    end else if (kind < 178) begin
      send_byte(pick_sep(), 1'b0);
    end else if (kind < 199) begin
      // raw noise bytes, any value
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 1'b0);
    end else if ($urandom_range(1) == 0) begin
      // rare word around the length limit
      n = $urandom_range(262, 250);
      for (i = 0; i < n; i++) send_byte(pick_alpha(), 1'b0);
    end
    if ($urandom_range(9) < 7) send_byte(pick_sep(), 1'b0);
    if ($urandom_range(99) < 5) send_byte(pick_any(), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_keywords();
    int k;
    for (k = 0; k < 13; k++) begin
      send_text(kw_spell[k], 1'b0);
      send_byte(CH_SPACE, 1'b0);
    end
    // near misses fall back to identifiers
    send_text("in ints Int\tchar_ ", 1'b0);
    send_byte(CH_LF, 1'b1);
  endtask

  task automatic test_word_classes();
    send_text("_aZ9 0129 9a a|b 12_ ", 1'b0);
    // control and high bytes are word bytes that make the word null
    send_byte(8'h00, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_text("x", 1'b1);
  endtask

  task automatic test_operators();
    send_text("++ -- += -= *= */ /= // /* %= <= >= != == + - * / % < > ! = ", 1'b0);
    send_text(";{}()[]& | a+b c&&d =+=- <<=== x", 1'b1);
  endtask

  // end_of_text on each kind of byte: pending operator and word flushed in order
  task automatic test_end_flush();
    send_text("ab+", 1'b1);
    send_text("+a", 1'b1);
    send_text("<<", 1'b1);
    send_text("x==", 1'b1);
    send_text("q;", 1'b1);
    send_text(" ", 1'b1);
    send_text("z", 1'b1);
    send_text("!\t", 1'b1);
    send_text("k\n", 1'b1);
  endtask

  task automatic test_long_words();
    int i;
    // exactly at the limit: a normal token
    for (i = 0; i < 255; i++) send_byte(pick_alpha(), 1'b0);
    send_byte(CH_SPACE, 1'b0);
    // one over: error token, later bytes start a fresh word
    for (i = 0; i < 256; i++) send_byte(pick_digit(), 1'b0);
    send_text("dd ", 1'b0);
    // one over on the final byte
    for (i = 0; i < 255; i++) send_byte(CH_LA + 8'(i % 26), 1'b0);
    send_byte(CH_LA, 1'b1);
  endtask

  task automatic test_random_text(input int n);
    int goal;
    goal = bytes_sent + n;
    while (bytes_sent < goal) send_fragment();
  endtask

  task automatic test_no_idle_stretch();
    int goal;
    goal  = bytes_sent + 300;
    quiet = 1'b1;
    while (bytes_sent < goal) send_fragment();
    quiet = 1'b0;
  endtask

  // Token side holds off while text keeps coming; the block must fill and
  // push back on text_stall without losing a byte.
  task automatic test_backpressure();
    int i;
    quiet = 1'b1;
    hold_ticket++;
    for (i = 0; i < 20; i++) send_text("x+;{ ", 1'b0);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_keywords();
    test_word_classes();
    test_operators();
    test_end_flush();
    test_long_words();
    test_random_text(250);
    test_no_idle_stretch();
    test_backpressure();
    test_random_text(150);
    send_byte(CH_SPACE, 1'b1);

    @(negedge clk) text_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (err_count == 0 && token_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
